// ----- rtl/ssp_pkg.sv -----
package ssp_pkg;

  localparam int unsigned QUOT_W     = 26;
  localparam int unsigned STEPS_W    = 31;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned MOVE_W     = 32;
  localparam int unsigned SPR_W      = 16;
  localparam int unsigned MODE_W     = 4;
  localparam int unsigned RPM_W      = 16;
  localparam int unsigned PROD_W     = SPR_W + 1 + RPM_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIV_CNT_W  = 5;

  localparam logic [QUOT_W-1:0]    PERIOD_NUMER = 26'd60000000;
  localparam logic [QUOT_W-1:0]    IDLE_PERIOD  = 26'd1000000;
  localparam int unsigned          RESET_PERIOD = 1000;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST     = DIV_CNT_W'(QUOT_W - 1);

  localparam logic [SPR_W-1:0]  SPR_RESET  = 16'd200;
  localparam logic [MODE_W-1:0] MODE_RESET = 4'd4;
  localparam logic [RPM_W-1:0]  RPM_RESET  = 16'd0;
  localparam logic [MODE_W-1:0] MODE_MAX   = 4'd8;
  localparam logic [MODE_W-1:0] MODE_OVER  = 4'd4;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_MOVE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPR  = 2'd0,
    CFG_MODE = 2'd1,
    CFG_RPM  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic tick;
    logic move;
    logic div_step;
    logic div_fin;
  } ssp_cmd_t;

  typedef struct packed {
    logic div_last;
  } ssp_status_t;

endpackage

// ----- rtl/ssp_in_if.sv -----
interface ssp_in_if;
  import ssp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     func;
  logic signed [MOVE_W-1:0] move_steps;

  modport source (output valid, func, move_steps, input ready);
  modport sink (input valid, func, move_steps, output ready);
endinterface

// ----- rtl/ssp_out_if.sv -----
interface ssp_out_if;
  import ssp_pkg::*;

  logic             valid;
  logic             ready;
  logic             step_pulse;
  logic             direction;
  logic [POS_W-1:0] position;
  logic             busy_res;

  modport source (output valid, step_pulse, direction, position, busy_res, input ready);
  modport sink (input valid, step_pulse, direction, position, busy_res, output ready);
endinterface

// ----- rtl/ssp_cfg_if.sv -----
interface ssp_cfg_if;
  import ssp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/ssp_ctrl.sv -----
module ssp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_func,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ssp_pkg::ssp_status_t status,
  output ssp_pkg::ssp_cmd_t    cmd
);
  import ssp_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        accept;

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.tick     = accept && (in_func == FUNC_TICK);
    cmd.move     = accept && (in_func == FUNC_MOVE);
    cmd.div_step = (state_r == ST_DIV);
    cmd.div_fin  = (state_r == ST_FIN);

    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.move) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("input accepted while the divider is running");

  a_move_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.move |=> (state_r == ST_DIV))
    else $error("move item did not start the period division");

  a_fin_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> (state_r == ST_IDLE))
    else $error("controller did not return to idle after the division");

endmodule

// ----- rtl/ssp_dp.sv -----
module ssp_dp #(
  parameter int unsigned TIMER_WIDTH = 26
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ssp_pkg::ssp_cmd_t                 cmd,
  output ssp_pkg::ssp_status_t              status,
  input  logic [ssp_pkg::SPR_W-1:0]         steps_per_rev,
  input  logic [ssp_pkg::MODE_W-1:0]        microstep_mode,
  input  logic [ssp_pkg::RPM_W-1:0]         rpm,
  input  logic signed [ssp_pkg::MOVE_W-1:0] move_steps,
  output logic                              step_pulse,
  output logic                              direction,
  output logic [ssp_pkg::POS_W-1:0]         position,
  output logic                              busy_res
);
  import ssp_pkg::*;

  localparam int unsigned EXT_W = (TIMER_WIDTH > QUOT_W) ? TIMER_WIDTH : QUOT_W;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [STEPS_W-1:0]     steps_r, steps_nxt;
  logic [TIMER_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic [TIMER_WIDTH-1:0] period_r, period_nxt;
  logic                   dir_r, dir_nxt;

  logic [PROD_W-1:0]      prod_r;
  logic                   rpm_zero_r;
  logic [QUOT_W-1:0]      quo_r, quo_nxt;
  logic [QUOT_W-1:0]      rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r;

  logic                   pulse_r;
  logic                   dir_out_r;
  logic [POS_W-1:0]       pos_out_r;
  logic                   busy_out_r;

  logic [SPR_W:0]         modulus;
  logic [MODE_W-1:0]      shift;
  logic [TIMER_WIDTH-1:0] el_inc;
  logic                   fire;
  logic [MOVE_W-1:0]      raw;
  logic [MOVE_W-1:0]      neg_mag;
  logic [STEPS_W-1:0]     mag;
  logic [QUOT_W:0]        trial;
  logic                   ge;
  logic [QUOT_W-1:0]      q_sel;
  logic [EXT_W-1:0]       q_ext;

  assign modulus = (steps_per_rev == '0) ? {1'b1, {SPR_W{1'b0}}} : {1'b0, steps_per_rev};
  assign shift   = (microstep_mode > MODE_MAX) ? MODE_OVER : microstep_mode;

  assign el_inc = (elapsed_r == TIMER_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign fire   = (steps_r != '0) && (el_inc >= period_r);

  assign raw     = move_steps;
  assign neg_mag = ~raw + 1'b1;
  assign mag     = raw[MOVE_W-1] ? (neg_mag[MOVE_W-1] ? {STEPS_W{1'b1}} : neg_mag[STEPS_W-1:0])
                                 : raw[STEPS_W-1:0];

  assign trial = {rem_r, quo_r[QUOT_W-1]};
  assign ge    = PROD_W'(trial) >= prod_r;
  assign q_sel = rpm_zero_r ? IDLE_PERIOD : quo_r;
  assign q_ext = EXT_W'(q_sel);

  assign status.div_last = (cnt_r == DIV_LAST);

  always_comb begin
    pos_nxt     = pos_r;
    steps_nxt   = steps_r;
    elapsed_nxt = elapsed_r;
    period_nxt  = period_r;
    dir_nxt     = dir_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;

    if (cmd.tick) begin
      elapsed_nxt = el_inc;
      if (fire) begin
        elapsed_nxt = '0;
        steps_nxt   = steps_r - 1'b1;
        if (dir_r) begin
          if (({1'b0, pos_r} + 1'b1) >= modulus) begin
            pos_nxt = '0;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end else begin
          if ((pos_r == '0) || ({1'b0, pos_r} >= modulus)) begin
            pos_nxt = POS_W'(modulus - 1'b1);
          end else begin
            pos_nxt = pos_r - 1'b1;
          end
        end
      end
    end

    if (cmd.move) begin
      steps_nxt = mag;
      dir_nxt   = !raw[MOVE_W-1] && (raw != '0);
      quo_nxt   = PERIOD_NUMER >> shift;
      rem_nxt   = '0;
    end

    if (cmd.div_step) begin
      quo_nxt = {quo_r[QUOT_W-2:0], ge};
      rem_nxt = ge ? QUOT_W'(PROD_W'(trial) - prod_r) : trial[QUOT_W-1:0];
    end

    if (cmd.div_fin) begin
      if (q_ext == '0) begin
        period_nxt = TIMER_WIDTH'(1);
      end else if (q_ext > EXT_W'(TIMER_MAX)) begin
        period_nxt = TIMER_MAX;
      end else begin
        period_nxt = TIMER_WIDTH'(q_ext);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      steps_r   <= '0;
      elapsed_r <= TIMER_MAX;
      period_r  <= TIMER_WIDTH'(RESET_PERIOD);
      dir_r     <= 1'b1;
      cnt_r     <= '0;
    end else begin
      pos_r     <= pos_nxt;
      steps_r   <= steps_nxt;
      elapsed_r <= elapsed_nxt;
      period_r  <= period_nxt;
      dir_r     <= dir_nxt;
      if (cmd.move) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (cmd.move) begin
      prod_r     <= PROD_W'(modulus) * PROD_W'(rpm);
      rpm_zero_r <= (rpm == '0);
    end
    if (cmd.tick || cmd.move) begin
      pulse_r    <= cmd.tick && fire;
      dir_out_r  <= dir_nxt;
      pos_out_r  <= pos_nxt;
      busy_out_r <= (steps_nxt != '0);
    end
  end

  assign step_pulse = pulse_r;
  assign direction  = dir_out_r;
  assign position   = pos_out_r;
  assign busy_res   = busy_out_r;

  a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    period_r != '0)
    else $error("step period reached zero");

  a_step_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tick && fire) |=> (steps_r + 1'b1 == $past(steps_r)))
    else $error("issued step did not decrement the remaining count");

  a_move_keeps_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.move |=> $stable(elapsed_r))
    else $error("move item changed the elapsed counter");

endmodule

// ----- rtl/stepper_step_pulse_generator.sv -----
// Channel  Dir  Fields                                       Accepted when
// in_ch    in   func, move_steps                             in_ch.valid && in_ch.ready
// out_ch   out  step_pulse, direction, position, busy_res    out_ch.valid && out_ch.ready
// cfg_ch   in   index, data                                  cfg_ch.valid && cfg_ch.ready
//
// A tick item's result is registered at the same edge that takes it. A move item holds
// the input through the ST_DIV and ST_FIN states: its result is registered at once, then
// the period is found by a restoring divider that produces one quotient bit per cycle.
// Synchronous active-low reset; the configuration port is always ready.
// A result waiting on out_ch blocks only the next item until it is taken.
module stepper_step_pulse_generator #(
  parameter int unsigned TIMER_WIDTH = 26
) (
  input logic        clk,
  input logic        rst_n,
  ssp_in_if.sink     in_ch,
  ssp_out_if.source  out_ch,
  ssp_cfg_if.sink    cfg_ch
);
  import ssp_pkg::*;

  logic [SPR_W-1:0]  spr_r, spr_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [RPM_W-1:0]  rpm_r, rpm_nxt;

  ssp_cmd_t    cmd;
  ssp_status_t status;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    spr_nxt  = spr_r;
    mode_nxt = mode_r;
    rpm_nxt  = rpm_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_SPR:  spr_nxt  = cfg_ch.data;
        CFG_MODE: mode_nxt = cfg_ch.data[MODE_W-1:0];
        CFG_RPM:  rpm_nxt  = cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r  <= SPR_RESET;
      mode_r <= MODE_RESET;
      rpm_r  <= RPM_RESET;
    end else begin
      spr_r  <= spr_nxt;
      mode_r <= mode_nxt;
      rpm_r  <= rpm_nxt;
    end
  end

  ssp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ssp_dp #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .steps_per_rev  (spr_r),
    .microstep_mode (mode_r),
    .rpm            (rpm_r),
    .move_steps     (in_ch.move_steps),
    .step_pulse     (out_ch.step_pulse),
    .direction      (out_ch.direction),
    .position       (out_ch.position),
    .busy_res       (out_ch.busy_res)
  );

endmodule

// ----- test/stepper_step_pulse_generator_tb.sv -----
module stepper_step_pulse_generator_tb;
  import ssp_pkg::*;

  localparam int TIMER_W = 26;
  localparam longint unsigned TIMER_TOP = (64'd1 << TIMER_W) - 1;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 135;
  localparam int PLAN_ROWS = 28;

  typedef struct packed {
    logic             pulse;
    logic             dir;
    logic [POS_W-1:0] pos;
    logic             busy;
  } step_result_t;

  typedef enum bit {ROW_ITEM, ROW_SETUP} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic                     func;
    logic signed [MOVE_W-1:0] steps;
    bit                       typed;
    step_result_t             res;
    logic [SPR_W-1:0]         spr;
    logic [MODE_W-1:0]        mode;
    logic [RPM_W-1:0]         rpm;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ssp_in_if  in_ch ();
  ssp_out_if out_ch ();
  ssp_cfg_if cfg_ch ();

  stepper_step_pulse_generator #(.TIMER_WIDTH(TIMER_W)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  logic [SPR_W-1:0]   reg_spr;
  logic [MODE_W-1:0]  reg_mode;
  logic [RPM_W-1:0]   reg_rpm;
  logic [POS_W-1:0]   pos_q;
  logic [30:0]        left_q;
  logic [TIMER_W-1:0] elapsed_q;
  logic [TIMER_W-1:0] period_q;
  logic               dir_q;

  step_result_t pending_results[$];
  plan_row_t    plan [PLAN_ROWS];

  int  errors = 0;
  int  item_count = 0;
  int  move_count = 0;
  int  pulse_count = 0;
  int  setting_count = 0;
  bit  in_dense = 1'b0;
  bit  out_dense = 1'b0;
  bit  hold_request = 1'b0;

  function automatic int draw_wait(bit dense);
    return dense ? 0 : int'($urandom_range(0, 10));
  endfunction

  function automatic logic [TIMER_W-1:0] motor_period();
    longint unsigned modv;
    longint unsigned micro;
    longint unsigned divisor;
    longint unsigned q;
    if (reg_rpm == 0) begin
      q = 1000000;
    end else begin
      modv = (reg_spr == 0) ? 65536 : reg_spr;
      micro = (reg_mode > MODE_MAX) ? 16 : (64'd1 << reg_mode);
      divisor = modv * micro * reg_rpm;
      q = 64'd60000000 / divisor;
      if (q < 1) q = 1;
    end
    if (q > TIMER_TOP) q = TIMER_TOP;
    return q[TIMER_W-1:0];
  endfunction

  function automatic step_result_t advance_motor(logic f, logic signed [MOVE_W-1:0] s);
    step_result_t r;
    logic [MOVE_W-1:0] mag;
    logic [16:0] modv;
    r.pulse = 1'b0;
    if (f == FUNC_MOVE) begin
      if (s < 0) begin
        mag = -s;
        if (mag > 32'h7FFF_FFFF) mag = 32'h7FFF_FFFF;
        dir_q = 1'b0;
      end else begin
        mag = s;
        dir_q = (s != 0);
      end
      left_q = mag[30:0];
      period_q = motor_period();
    end else begin
      if (elapsed_q != TIMER_TOP[TIMER_W-1:0]) elapsed_q = elapsed_q + 1'b1;
      if (left_q != 0 && elapsed_q >= period_q) begin
        modv = (reg_spr == 0) ? 17'd65536 : {1'b0, reg_spr};
        r.pulse = 1'b1;
        elapsed_q = '0;
        left_q = left_q - 1'b1;
        if (dir_q) begin
          if ({1'b0, pos_q} + 17'd1 >= modv) pos_q = '0;
          else pos_q = pos_q + 1'b1;
        end else begin
          if (pos_q == 0 || {1'b0, pos_q} >= modv) pos_q = 16'(modv - 17'd1);
          else pos_q = pos_q - 1'b1;
        end
      end
    end
    r.dir = dir_q;
    r.pos = pos_q;
    r.busy = (left_q != 0);
    return r;
  endfunction

  task automatic send_item(input logic f, input logic signed [MOVE_W-1:0] s,
                           input bit typed, input step_result_t typed_res);
    int gap;
    step_result_t r;
    gap = draw_wait(in_dense);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.move_steps <= s;
    do @(posedge clk); while (!in_ch.ready);
    r = advance_motor(f, s);
    pending_results.push_back(typed ? typed_res : r);
    item_count++;
    if (f == FUNC_MOVE) move_count++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [SPR_W-1:0] spr, input logic [MODE_W-1:0] mode,
                            input logic [RPM_W-1:0] rpm);
    cfg_idx_t idx;
    logic [CFG_DATA_W-1:0] val;
    for (int i = 0; i < 3; i++) begin
      case (i)
        0: begin
          idx = CFG_SPR;
          val = spr;
        end
        1: begin
          idx = CFG_MODE;
          val = CFG_DATA_W'(mode);
        end
        default: begin
          idx = CFG_RPM;
          val = rpm;
        end
      endcase
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data <= val;
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    reg_spr = spr;
    reg_mode = mode;
    reg_rpm = rpm;
    setting_count++;
  endtask

  function automatic logic signed [MOVE_W-1:0] pick_steps();
    case ($urandom_range(0, 11))
      0, 1: return $urandom;
      2: return 0;
      3: return 32'sh8000_0000;
      4: return 32'sh7FFF_FFFF;
      5: return -int'($urandom_range(100, 5000));
      default: return int'($urandom_range(0, 40)) - 20;
    endcase
  endfunction

  initial begin
    plan = '{
      '{ROW_ITEM, FUNC_TICK, 0, 1, '{1'b0, 1'b1, 16'd0, 1'b0}, 0, 0, 0},
      '{ROW_ITEM, FUNC_MOVE, 0, 1, '{1'b0, 1'b0, 16'd0, 1'b0}, 0, 0, 0},
      '{ROW_ITEM, FUNC_TICK, 0, 1, '{1'b0, 1'b0, 16'd0, 1'b0}, 0, 0, 0},
      '{ROW_ITEM, FUNC_MOVE, 32'sh8000_0000, 1, '{1'b0, 1'b0, 16'd0, 1'b1}, 0, 0, 0},
      '{ROW_ITEM, FUNC_TICK, 0, 1, '{1'b1, 1'b0, 16'd199, 1'b1}, 0, 0, 0},
      '{ROW_ITEM, FUNC_TICK, -1, 1, '{1'b0, 1'b0, 16'd199, 1'b1}, 0, 0, 0},
      '{ROW_ITEM, FUNC_MOVE, 3, 1, '{1'b0, 1'b1, 16'd199, 1'b1}, 0, 0, 0},
      '{ROW_ITEM, FUNC_MOVE, 32'sh7FFF_FFFF, 1, '{1'b0, 1'b1, 16'd199, 1'b1}, 0, 0, 0},
      '{ROW_SETUP, FUNC_TICK, 0, 0, '0, 16'd10, 4'd15, 16'd65535},
      '{ROW_ITEM, FUNC_MOVE, -1, 1, '{1'b0, 1'b0, 16'd199, 1'b1}, 0, 0, 0},
      '{ROW_ITEM, FUNC_TICK, 0, 0, '0, 0, 0, 0},
      '{ROW_ITEM, FUNC_TICK, 0, 0, '0, 0, 0, 0},
      '{ROW_ITEM, FUNC_TICK, 0, 0, '0, 0, 0, 0},
      '{ROW_ITEM, FUNC_TICK, 0, 0, '0, 0, 0, 0},
      '{ROW_ITEM, FUNC_TICK, 0, 0, '0, 0, 0, 0},
      '{ROW_ITEM, FUNC_TICK, 0, 0, '0, 0, 0, 0},
      '{ROW_SETUP, FUNC_TICK, 0, 0, '0, 16'd5, 4'd8, 16'd65535},
      '{ROW_ITEM, FUNC_MOVE, 2, 0, '0, 0, 0, 0},
      '{ROW_ITEM, FUNC_TICK, 0, 0, '0, 0, 0, 0},
      '{ROW_ITEM, FUNC_TICK, 0, 0, '0, 0, 0, 0},
      '{ROW_SETUP, FUNC_TICK, 0, 0, '0, 16'd0, 4'd8, 16'd65535},
      '{ROW_ITEM, FUNC_MOVE, -3, 0, '0, 0, 0, 0},
      '{ROW_ITEM, FUNC_TICK, 0, 0, '0, 0, 0, 0},
      '{ROW_ITEM, FUNC_TICK, 0, 0, '0, 0, 0, 0},
      '{ROW_ITEM, FUNC_TICK, 0, 0, '0, 0, 0, 0},
      '{ROW_ITEM, FUNC_MOVE, -32'sd2147483647, 0, '0, 0, 0, 0},
      '{ROW_ITEM, FUNC_TICK, 0, 0, '0, 0, 0, 0},
      '{ROW_ITEM, FUNC_TICK, 0, 0, '0, 0, 0, 0}
    };
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int target;
    int ticks;
    int spr_v;
    int rpm_v;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func <= FUNC_TICK;
    in_ch.move_steps <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_SPR;
    cfg_ch.data <= '0;
    reg_spr = SPR_RESET;
    reg_mode = MODE_RESET;
    reg_rpm = RPM_RESET;
    pos_q = '0;
    left_q = '0;
    elapsed_q = TIMER_TOP[TIMER_W-1:0];
    period_q = TIMER_W'(RESET_PERIOD);
    dir_q = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SETUP) begin
        drain_results();
        write_regs(plan[i].spr, plan[i].mode, plan[i].rpm);
      end else begin
        send_item(plan[i].func, plan[i].steps, plan[i].typed, plan[i].res);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case ($urandom_range(0, 5))
        0: spr_v = 0;
        1: spr_v = 65535;
        2: spr_v = 1;
        default: spr_v = $urandom_range(2, 400);
      endcase
      case ($urandom_range(0, 5))
        0: rpm_v = 0;
        1: rpm_v = 65535;
        default: rpm_v = $urandom_range(5000, 65535);
      endcase
      write_regs(SPR_W'(spr_v), MODE_W'($urandom_range(0, 15)), RPM_W'(rpm_v));
      in_dense = ($urandom_range(0, 3) == 0) || (p == 2);
      out_dense = ($urandom_range(0, 3) == 0);
      if (p == 2) hold_request = 1'b1;
      target = item_count + PHASE_ITEMS;
      while (item_count < target) begin
        if ($urandom_range(0, 9) < 7) begin
          send_item(FUNC_MOVE, pick_steps(), 1'b0, '0);
          if (period_q <= 8) ticks = period_q * $urandom_range(1, 6) + $urandom_range(0, 2);
          else ticks = $urandom_range(1, 12);
          if (ticks > 60) ticks = 60;
          repeat (ticks) send_item(FUNC_TICK, $urandom, 1'b0, '0);
        end else if ($urandom_range(0, 1) == 0) begin
          send_item(FUNC_MOVE, $urandom, 1'b0, '0);
        end else begin
          send_item(FUNC_TICK, $urandom, 1'b0, '0);
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d items (%0d moves) with %0d step pulses over %0d register settings,",
             item_count, move_count, pulse_count, setting_count);
    $display("with random gaps on both sides and a long stall on the result side.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches found.", errors);
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    int stall;
    step_result_t want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall = draw_wait(out_dense);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (out_ch.step_pulse === 1'b1) pulse_count++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Result with no item pending at %0t.", $realtime);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.step_pulse !== want.pulse || out_ch.direction !== want.dir ||
            out_ch.position !== want.pos || out_ch.busy_res !== want.busy) begin
          errors++;
          if (errors <= 10) begin
            $display("Mismatch at %0t: pulse %b/%b dir %b/%b pos %0d/%0d busy %b/%b (exp/got)",
                     $realtime, want.pulse, out_ch.step_pulse, want.dir, out_ch.direction,
                     want.pos, out_ch.position, want.busy, out_ch.busy_res);
          end
        end
      end
    end
  end

endmodule

// ----- files.f -----
rtl/ssp_pkg.sv
rtl/ssp_in_if.sv
rtl/ssp_out_if.sv
rtl/ssp_cfg_if.sv
rtl/ssp_ctrl.sv
rtl/ssp_dp.sv
rtl/stepper_step_pulse_generator.sv
test/stepper_step_pulse_generator_tb.sv
